// File: hdl/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/psg_pkg.sv
package psg_pkg;

    localparam int NUM_CHIPS_DEF = 2;
    localparam int NUM_REGS_DEF  = 16;
    localparam int NUM_CHANNELS  = 3;

    localparam int STEP_W = 24;
    localparam int ACC_W  = 33;
    localparam int AMP_W  = 13;

    localparam logic [2:0] OP_LATCH = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_RESET = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    localparam logic [1:0] CFG_TONE  = 2'd0;
    localparam logic [1:0] CFG_ENV   = 2'd1;
    localparam logic [1:0] CFG_NOISE = 2'd2;

    localparam logic [STEP_W-1:0] TONE_STEP_RST  = 24'd190032;
    localparam logic [STEP_W-1:0] ENV_STEP_RST   = 24'd95016;
    localparam logic [STEP_W-1:0] NOISE_STEP_RST = 24'd95016;

    localparam logic [2:0] PH_NOISE = 3'd0;
    localparam logic [2:0] PH_ENV   = 3'd1;
    localparam logic [2:0] PH_TONE0 = 3'd2;
    localparam logic [2:0] PH_TONE2 = 3'd4;

    localparam logic [3:0] REG_MIX     = 4'd7;
    localparam logic [3:0] REG_NOISE   = 4'd6;
    localparam logic [3:0] REG_VOL0    = 4'd8;
    localparam logic [3:0] REG_ENV_LO  = 4'd11;
    localparam logic [3:0] REG_ENV_HI  = 4'd12;
    localparam logic [3:0] REG_SHAPE   = 4'd13;
    localparam logic [7:0] SHAPE_DONE  = 8'hFF;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_SUB  = 4'b0100,
        S_OUT  = 4'b1000
    } psg_state_t;

    function automatic logic [AMP_W-1:0] psg_amp(input logic [3:0] lvl);
        logic [AMP_W-1:0] a;
        unique case (lvl)
            4'd0:  a = 13'h0000;
            4'd1:  a = 13'h0056;
            4'd2:  a = 13'h007E;
            4'd3:  a = 13'h00B1;
            4'd4:  a = 13'h0101;
            4'd5:  a = 13'h0179;
            4'd6:  a = 13'h0208;
            4'd7:  a = 13'h0365;
            4'd8:  a = 13'h0438;
            4'd9:  a = 13'h06EC;
            4'd10: a = 13'h0983;
            4'd11: a = 13'h0C81;
            4'd12: a = 13'h1069;
            4'd13: a = 13'h1463;
            4'd14: a = 13'h1A31;
            default: a = 13'h1FFF;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/psg_sub_unit.sv
module psg_sub_unit
    import psg_pkg::*;
(
    input  logic [ACC_W-1:0] minuend,
    input  logic [ACC_W-1:0] subtrahend,
    output logic             ge,
    output logic [ACC_W-1:0] diff
);

    logic [ACC_W:0] wide;

    // one borrow chain gives both compare and difference
    assign wide = {1'b0, minuend} - {1'b0, subtrahend};
    assign ge   = ~wide[ACC_W];
    assign diff = wide[ACC_W-1:0];

endmodule

// File: hdl/psg_sound_generator_pair.sv
// bus requests (latch, write, read, chip reset) are handled in the idle state; a read result is
// registered and offered on the next cycle
// a sample tick runs the noise, envelope and tone period subtractions of each
// chip, one per cycle in the shared 33-bit subtractor (at most about 256 each
// per generator)
// rst_n clears all generator state and sets the phase steps to their defaults
module psg_sound_generator_pair
    import psg_pkg::*;
#(
    parameter int NUM_CHIPS = NUM_CHIPS_DEF,
    parameter int NUM_REGS  = NUM_REGS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration writes
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [STEP_W-1:0]        cfg_data,
    // request channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               operation,
    input  logic                     chip,
    input  logic [7:0]               bus_data,
    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     result_kind,
    output logic [7:0]               read_data,
    output logic signed [15:0]       sample
);

`include "assert_macros.svh"

    localparam int CHIP_W = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
    localparam int SUM_W  = AMP_W + $clog2(NUM_CHIPS * NUM_CHANNELS) + 1;

    // per-chip register file and generator state
    logic [7:0]  regs_reg   [NUM_CHIPS][NUM_REGS];
    logic [3:0]  latch_reg  [NUM_CHIPS];
    logic [28:0] tcnt_reg   [NUM_CHIPS][NUM_CHANNELS];
    logic        tlev_reg   [NUM_CHIPS][NUM_CHANNELS];
    logic [21:0] ncnt_reg   [NUM_CHIPS];
    logic [16:0] lfsr_reg   [NUM_CHIPS];
    logic [31:0] ecnt_reg   [NUM_CHIPS];
    logic [3:0]  elev_reg   [NUM_CHIPS];
    logic        erise_reg  [NUM_CHIPS];
    logic [3:0]  eshape_reg [NUM_CHIPS];
    logic        ehold_reg  [NUM_CHIPS];

    logic [STEP_W-1:0] tone_step_reg, env_step_reg, noise_step_reg;

    // sequencer
    psg_state_t        state_reg;
    logic [CHIP_W-1:0] chip_reg;
    logic [2:0]        phase_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  sum_reg;

    // output register
    logic              out_valid_reg;
    logic              result_kind_reg;
    logic [7:0]        read_data_reg;
    logic [15:0]       sample_reg;

    logic              in_accept;
    logic              out_load;
    logic [CHIP_W-1:0] bus_chip;
    logic              bus_chip_ok;
    logic [1:0]        cidx;
    logic [3:0]        tlo_idx, thi_idx, vol_idx;
    logic [11:0]       tper;
    logic [4:0]        nper;
    logic [15:0]       eper;
    logic [ACC_W-1:0]  per_sel, cnt_sel, step_sel;
    logic              sub_ge;
    logic [ACC_W-1:0]  sub_diff;
    logic [7:0]        wr_r13;
    logic [5:0]        env_nl;
    logic [7:0]        mix, vol;
    logic [AMP_W-1:0]  amp;
    logic              chan_on;
    logic [SUM_W-1:0]  sum_fin;

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    assign bus_chip    = CHIP_W'(chip);
    assign bus_chip_ok = int'(chip) < NUM_CHIPS;

    // a read answer or a finished tick loads the output register
    assign out_load = (state_reg == S_IDLE && in_accept && bus_chip_ok
                       && operation == OP_READ)
                   || (state_reg == S_OUT && (!out_valid_reg || !out_stall));

    // period selection for the generator under work, 0 forced to 1
    assign cidx    = 2'(phase_reg - PH_TONE0);
    assign tlo_idx = 4'({cidx, 1'b0});
    assign thi_idx = 4'({cidx, 1'b1});
    assign vol_idx = REG_VOL0 + 4'(cidx);

    always_comb
    begin
        tper = {regs_reg[chip_reg][thi_idx][3:0], regs_reg[chip_reg][tlo_idx]};
        if (tper == '0) tper = 12'd1;
        nper = regs_reg[chip_reg][REG_NOISE][4:0];
        if (nper == '0) nper = 5'd1;
        eper = {regs_reg[chip_reg][REG_ENV_HI], regs_reg[chip_reg][REG_ENV_LO]};
        if (eper == '0) eper = 16'd1;
    end

    always_comb
    begin
        priority if (phase_reg == PH_NOISE)
        begin
            per_sel  = {12'b0, nper, 16'b0};
            cnt_sel  = {11'b0, ncnt_reg[chip_reg]};
            step_sel = {9'b0, noise_step_reg};
        end
        else if (phase_reg == PH_ENV)
        begin
            per_sel  = {1'b0, eper, 16'b0};
            cnt_sel  = {1'b0, ecnt_reg[chip_reg]};
            step_sel = {9'b0, env_step_reg};
        end
        else
        begin
            per_sel  = {5'b0, tper, 16'b0};
            cnt_sel  = {4'b0, tcnt_reg[chip_reg][cidx]};
            step_sel = {9'b0, tone_step_reg};
        end
    end

    psg_sub_unit u_sub
    (
        .minuend    (acc_reg),
        .subtrahend (per_sel),
        .ge         (sub_ge),
        .diff       (sub_diff)
    );

    // envelope level one step on, in a signed 6-bit view
    assign env_nl = {2'b0, elev_reg[chip_reg]} + (erise_reg[chip_reg] ? 6'd1 : 6'h3F);

    // channel gate and amplitude for the tone being finished
    assign mix     = regs_reg[chip_reg][REG_MIX];
    assign vol     = regs_reg[chip_reg][vol_idx];
    assign amp     = vol[4] ? psg_amp(elev_reg[chip_reg]) : psg_amp(vol[3:0]);
    assign chan_on = (tlev_reg[chip_reg][cidx] || mix[cidx])
                  && (lfsr_reg[chip_reg][0] || mix[3 + cidx]);

    assign sum_fin = (sum_reg > SUM_W'(16'h7FFF)) ? SUM_W'(16'h7FFF) : sum_reg;

    // shape register value as it stands after a write
    assign wr_r13 = (latch_reg[bus_chip] == REG_SHAPE) ? bus_data
                                                     : regs_reg[bus_chip][REG_SHAPE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHIPS; i++)
            begin
                for (int r = 0; r < NUM_REGS; r++) regs_reg[i][r] <= '0;
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    tcnt_reg[i][c] <= '0;
                    tlev_reg[i][c] <= 1'b0;
                end
                latch_reg[i]  <= '0;
                ncnt_reg[i]   <= '0;
                lfsr_reg[i]   <= 17'd1;
                ecnt_reg[i]   <= '0;
                elev_reg[i]   <= '0;
                erise_reg[i]  <= 1'b1;
                eshape_reg[i] <= '0;
                ehold_reg[i]  <= 1'b0;
            end
            tone_step_reg   <= TONE_STEP_RST;
            env_step_reg    <= ENV_STEP_RST;
            noise_step_reg  <= NOISE_STEP_RST;
            state_reg       <= S_IDLE;
            chip_reg        <= '0;
            phase_reg       <= PH_NOISE;
            acc_reg         <= '0;
            sum_reg         <= '0;
            out_valid_reg   <= 1'b0;
            result_kind_reg <= 1'b0;
            read_data_reg   <= '0;
            sample_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TONE)  tone_step_reg  <= cfg_data;
                if (cfg_index == CFG_ENV)   env_step_reg   <= cfg_data;
                if (cfg_index == CFG_NOISE) noise_step_reg <= cfg_data;
            end

            // new result loads, else a result taken downstream empties the register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && operation == OP_TICK)
                    begin
                        chip_reg  <= '0;
                        phase_reg <= PH_NOISE;
                        sum_reg   <= '0;
                        state_reg <= S_LOAD;
                    end
                    else if (in_accept && bus_chip_ok)
                    begin
                        if (operation == OP_LATCH)
                            latch_reg[bus_chip] <= bus_data[3:0];
                        if (operation == OP_WRITE && int'(latch_reg[bus_chip]) < NUM_REGS)
                        begin
                            // the shape register always ends up marked consumed
                            regs_reg[bus_chip][latch_reg[bus_chip]] <=
                                (latch_reg[bus_chip] == REG_SHAPE) ? SHAPE_DONE : bus_data;
                            // envelope restart unless shape already consumed
                            if (wr_r13 != SHAPE_DONE)
                            begin
                                if (latch_reg[bus_chip] != REG_SHAPE)
                                    regs_reg[bus_chip][REG_SHAPE] <= SHAPE_DONE;
                                eshape_reg[bus_chip] <= wr_r13[3:0];
                                ecnt_reg[bus_chip]   <= '0;
                                ehold_reg[bus_chip]  <= 1'b0;
                                erise_reg[bus_chip]  <= wr_r13[2];
                                elev_reg[bus_chip]   <= wr_r13[2] ? 4'd0 : 4'd15;
                            end
                        end
                        if (operation == OP_READ)
                        begin
                            result_kind_reg <= 1'b0;
                            sample_reg      <= '0;
                            read_data_reg   <= (int'(latch_reg[bus_chip]) < NUM_REGS)
                                             ? regs_reg[bus_chip][latch_reg[bus_chip]]
                                             : 8'd0;
                        end
                        if (operation == OP_RESET)
                        begin
                            for (int r = 0; r < NUM_REGS; r++) regs_reg[bus_chip][r] <= '0;
                            for (int c = 0; c < NUM_CHANNELS; c++)
                            begin
                                tcnt_reg[bus_chip][c] <= '0;
                                tlev_reg[bus_chip][c] <= 1'b0;
                            end
                            latch_reg[bus_chip]  <= '0;
                            ncnt_reg[bus_chip]   <= '0;
                            lfsr_reg[bus_chip]   <= 17'd1;
                            ecnt_reg[bus_chip]   <= '0;
                            elev_reg[bus_chip]   <= '0;
                            erise_reg[bus_chip]  <= 1'b1;
                            eshape_reg[bus_chip] <= '0;
                            ehold_reg[bus_chip]  <= 1'b0;
                        end
                    end
                end

                S_LOAD:
                begin
                    // a held envelope does not advance
                    if (phase_reg == PH_ENV && ehold_reg[chip_reg])
                        phase_reg <= PH_TONE0;
                    else
                    begin
                        acc_reg   <= cnt_sel + step_sel;
                        state_reg <= S_SUB;
                    end
                end

                S_SUB:
                begin
                    if (sub_ge && !(phase_reg == PH_ENV && ehold_reg[chip_reg]))
                    begin
                        acc_reg <= sub_diff;
                        priority if (phase_reg == PH_NOISE)
                            lfsr_reg[chip_reg] <= {lfsr_reg[chip_reg][0] ^ lfsr_reg[chip_reg][3],
                                                   lfsr_reg[chip_reg][16:1]};
                        else if (phase_reg == PH_ENV)
                        begin
                            if (env_nl == 6'd16 || env_nl == 6'h3F)
                            begin
                                priority if (!eshape_reg[chip_reg][3])
                                begin
                                    elev_reg[chip_reg]  <= 4'd0;
                                    ehold_reg[chip_reg] <= 1'b1;
                                end
                                else if (eshape_reg[chip_reg][0])
                                begin
                                    elev_reg[chip_reg]  <= (erise_reg[chip_reg] != eshape_reg[chip_reg][1])
                                                         ? 4'd15 : 4'd0;
                                    ehold_reg[chip_reg] <= 1'b1;
                                end
                                else if (eshape_reg[chip_reg][1])
                                begin
                                    // alternate: turn around, step back inside
                                    erise_reg[chip_reg] <= !erise_reg[chip_reg];
                                    elev_reg[chip_reg]  <= erise_reg[chip_reg] ? 4'd15 : 4'd0;
                                end
                                else
                                    elev_reg[chip_reg]  <= erise_reg[chip_reg] ? 4'd0 : 4'd15;
                            end
                            else
                                elev_reg[chip_reg] <= env_nl[3:0];
                        end
                        else
                            tlev_reg[chip_reg][cidx] <= !tlev_reg[chip_reg][cidx];
                    end
                    else
                    begin
                        // write the phase back and move to the next generator
                        priority if (phase_reg == PH_NOISE)
                            ncnt_reg[chip_reg] <= acc_reg[21:0];
                        else if (phase_reg == PH_ENV)
                            ecnt_reg[chip_reg] <= acc_reg[31:0];
                        else
                        begin
                            tcnt_reg[chip_reg][cidx] <= acc_reg[28:0];
                            if (chan_on) sum_reg <= sum_reg + SUM_W'(amp);
                        end

                        if (phase_reg == PH_TONE2)
                        begin
                            phase_reg <= PH_NOISE;
                            if (chip_reg == CHIP_W'(NUM_CHIPS - 1))
                                state_reg <= S_OUT;
                            else
                            begin
                                chip_reg  <= chip_reg + 1'b1;
                                state_reg <= S_LOAD;
                            end
                        end
                        else
                        begin
                            phase_reg <= phase_reg + 3'd1;
                            state_reg <= S_LOAD;
                        end
                    end
                end

                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        result_kind_reg <= 1'b1;
                        read_data_reg   <= '0;
                        sample_reg      <= sum_fin[15:0];
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = result_kind_reg;
    assign read_data   = read_data_reg;
    assign sample      = signed'(sample_reg);

    `ASSERT_IMPL(a_busy_stalls, clk, rst_n, state_reg != S_IDLE, in_stall)
    `ASSERT_IMPL(a_read_no_sample, clk, rst_n, out_valid_reg && !result_kind_reg, sample_reg == 16'd0)
    `ASSERT_IMPL(a_tick_clean, clk, rst_n, out_valid_reg && result_kind_reg, read_data_reg == 8'd0 && !sample_reg[15])
    `ASSERT_NEXT(a_out_done_idle, clk, rst_n, state_reg == S_OUT && !(out_valid_reg && out_stall), state_reg == S_IDLE && out_valid_reg)

endmodule

// File: test/psg_pair_checker.sv
`timescale 1ns / 100ps

module psg_pair_checker
    import psg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [STEP_W-1:0]   cfg_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [2:0]          operation,
    input  logic                chip,
    input  logic [7:0]          bus_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                result_kind,
    input  logic [7:0]          read_data,
    input  logic signed [15:0]  sample,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic        kind;
        logic [7:0]  rdata;
        logic [15:0] smp;
    } psg_result_t;

    localparam logic [15:0] LEVEL_AMP [16] = '{
        16'h0000, 16'h0056, 16'h007E, 16'h00B1, 16'h0101, 16'h0179, 16'h0208, 16'h0365,
        16'h0438, 16'h06EC, 16'h0983, 16'h0C81, 16'h1069, 16'h1463, 16'h1A31, 16'h1FFF
    };

    logic [7:0]        regs [2][16];
    logic [3:0]        addr_latch [2];
    logic [11:0]       tper [2][3];
    logic [63:0]       tcnt [2][3];
    logic              tlev [2][3];
    logic [4:0]        nper [2];
    logic [63:0]       ncnt [2];
    logic [16:0]       lfsr [2];
    logic [15:0]       eper [2];
    logic [63:0]       ecnt [2];
    int                elev [2];
    logic              erise [2];
    logic [3:0]        eshape [2];
    logic              ehold [2];
    logic [STEP_W-1:0] tone_step, env_step, noise_step;

    psg_result_t expected_results [$];

    task clear_chip(input int g);
        for (int i = 0; i < 16; i++)
            regs[g][i] = 8'h00;
        addr_latch[g] = 4'd0;
        for (int c = 0; c < 3; c++)
        begin
            tper[g][c] = 12'd1;
            tcnt[g][c] = 64'd0;
            tlev[g][c] = 1'b0;
        end
        nper[g] = 5'd1;
        ncnt[g] = 64'd0;
        lfsr[g] = 17'd1;
        eper[g] = 16'd1;
        ecnt[g] = 64'd0;
        elev[g] = 0;
        erise[g] = 1'b1;
        eshape[g] = 4'd0;
        ehold[g] = 1'b0;
    endtask

    // period refresh after any register write, plus envelope restart unless the shape is already consumed
    task reload_periods(input int g);
        logic [11:0] p;
        for (int c = 0; c < 3; c++)
        begin
            p = {regs[g][2*c+1][3:0], regs[g][2*c]};
            tper[g][c] = (p == 12'd0) ? 12'd1 : p;
        end
        nper[g] = (regs[g][6][4:0] == 5'd0) ? 5'd1 : regs[g][6][4:0];
        eper[g] = {regs[g][12], regs[g][11]};
        if (eper[g] == 16'd0)
            eper[g] = 16'd1;
        if (regs[g][13] != SHAPE_DONE)
        begin
            eshape[g] = regs[g][13][3:0];
            ecnt[g] = 64'd0;
            ehold[g] = 1'b0;
            erise[g] = eshape[g][2];
            elev[g] = eshape[g][2] ? 0 : 15;
            regs[g][13] = SHAPE_DONE;
        end
    endtask

    task advance_chip(input int g, output int amp_sum);
        logic [63:0] per;
        logic [63:0] q;
        logic        nout, tgate, ngate;
        logic [7:0]  vol;
        int          ea;
        amp_sum = 0;
        per = {43'd0, nper[g], 16'd0};
        ncnt[g] = ncnt[g] + noise_step;
        while (ncnt[g] >= per)
        begin
            ncnt[g] = ncnt[g] - per;
            lfsr[g] = {lfsr[g][0] ^ lfsr[g][3], lfsr[g][16:1]};
        end
        nout = lfsr[g][0];
        if (!ehold[g])
        begin
            per = {32'd0, eper[g], 16'd0};
            ecnt[g] = ecnt[g] + env_step;
            while (ecnt[g] >= per && !ehold[g])
            begin
                ecnt[g] = ecnt[g] - per;
                elev[g] = elev[g] + (erise[g] ? 1 : -1);
                if (elev[g] > 15 || elev[g] < 0)
                begin
                    if (!eshape[g][3])
                    begin
                        elev[g] = 0;
                        ehold[g] = 1'b1;
                    end
                    else if (eshape[g][0])
                    begin
                        elev[g] = (erise[g] != eshape[g][1]) ? 15 : 0;
                        ehold[g] = 1'b1;
                    end
                    else if (eshape[g][1])
                    begin
                        erise[g] = !erise[g];
                        elev[g] = elev[g] + (erise[g] ? 1 : -1);
                    end
                    else
                        elev[g] = erise[g] ? 0 : 15;
                end
            end
        end
        ea = (elev[g] < 0) ? 0 : ((elev[g] > 15) ? 15 : elev[g]);
        for (int c = 0; c < 3; c++)
        begin
            per = {36'd0, tper[g][c], 16'd0};
            tcnt[g][c] = tcnt[g][c] + tone_step;
            if (tcnt[g][c] >= per)
            begin
                q = tcnt[g][c] / per;
                tcnt[g][c] = tcnt[g][c] - q * per;
                if (q[0])
                    tlev[g][c] = !tlev[g][c];
            end
            tgate = tlev[g][c] || regs[g][REG_MIX][c];
            ngate = nout || regs[g][REG_MIX][3+c];
            if (tgate && ngate)
            begin
                vol = regs[g][REG_VOL0 + c];
                amp_sum += vol[4] ? LEVEL_AMP[ea] : LEVEL_AMP[vol[3:0]];
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        psg_result_t got, want;
        int          s0, s1, total;
        if (!rst_n)
        begin
            clear_chip(0);
            clear_chip(1);
            tone_step  = TONE_STEP_RST;
            env_step   = ENV_STEP_RST;
            noise_step = NOISE_STEP_RST;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TONE:  tone_step  = cfg_data;
                    CFG_ENV:   env_step   = cfg_data;
                    CFG_NOISE: noise_step = cfg_data;
                    default: ;
                endcase
            end
            // result side
            if (out_valid && !out_stall)
            begin
                got = '{result_kind, read_data, sample};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: kind %0d data %02h sample %0d",
                                 result_kind, read_data, sample);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp kind %0d data %02h sample %0d, got kind %0d data %02h sample %0d",
                                     want.kind, want.rdata, $signed(want.smp),
                                     got.kind, got.rdata, $signed(got.smp));
                    end
                end
            end
            // request side
            if (in_valid && !in_stall)
            begin
                case (operation)
                    OP_LATCH: addr_latch[chip] = bus_data[3:0];
                    OP_WRITE:
                    begin
                        regs[chip][addr_latch[chip]] = bus_data;
                        reload_periods(chip);
                    end
                    OP_READ:
                        expected_results.push_back('{1'b0, regs[chip][addr_latch[chip]], 16'd0});
                    OP_RESET: clear_chip(chip);
                    OP_TICK:
                    begin
                        advance_chip(0, s0);
                        advance_chip(1, s1);
                        total = s0 + s1;
                        if (total > 32767)
                            total = 32767;
                        expected_results.push_back('{1'b1, 8'd0, total[15:0]});
                    end
                    default: ;
                endcase
            end
            pending = expected_results.size();
        end
    end

endmodule

// File: test/psg_sound_generator_pair_tb.sv
`timescale 1ns / 100ps

module psg_sound_generator_pair_tb;
    import psg_pkg::*;

    // a tick runs with no handshake at all until its sample is offered
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PER_PHASE = 455;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = CFG_TONE;
    logic [STEP_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [2:0]        operation = OP_LATCH;
    logic              chip = 1'b0;
    logic [7:0]        bus_data = 8'd0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              result_kind;
    logic [7:0]        read_data;
    logic signed [15:0] sample;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    // clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    psg_sound_generator_pair dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .chip(chip), .bus_data(bus_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .read_data(read_data), .sample(sample)
    );

    psg_pair_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .chip(chip), .bus_data(bus_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .read_data(read_data), .sample(sample),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver backpressure, changes on the falling edge
    always @(negedge clk)
        out_stall = ($urandom_range(99) < stall_pct);

    // watchdog: cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one request, with random idle cycles ahead of it
    task send_request(input logic [2:0] op, input logic sel, input logic [7:0] data);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        operation = op;
        chip      = sel;
        bus_data  = data;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task write_reg(input logic sel, input logic [3:0] idx, input logic [7:0] data);
        send_request(OP_LATCH, sel, {4'd0, idx});
        send_request(OP_WRITE, sel, data);
    endtask

    task read_reg(input logic sel, input logic [3:0] idx);
        send_request(OP_LATCH, sel, {4'd0, idx});
        send_request(OP_READ, sel, 8'd0);
    endtask

    // bring the block to rest before touching configuration
    task drain;
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task set_step(input logic [1:0] idx, input logic [STEP_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // register data biased toward short periods so the outputs move
    function automatic logic [7:0] pick_data(input logic [3:0] idx);
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(255));
        case (idx)
            4'd0, 4'd2, 4'd4: return 8'($urandom_range(40));
            4'd1, 4'd3, 4'd5, 4'd12: return 8'd0;
            REG_ENV_LO: return 8'($urandom_range(8));
            REG_SHAPE: return 8'($urandom_range(15));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task random_requests(input int count);
        int          done;
        int          r;
        logic        sel;
        logic [3:0]  idx;
        done = 0;
        while (done < count)
        begin
            r   = $urandom_range(99);
            sel = 1'($urandom_range(1));
            idx = 4'($urandom_range(15));
            if (r < 35)
            begin
                write_reg(sel, idx, pick_data(idx));
                done += 2;
            end
            else if (r < 45)
            begin
                read_reg(sel, idx);
                done += 2;
            end
            else if (r < 50)
            begin
                // lone request with fully random data
                send_request(3'($urandom_range(2)), sel, 8'($urandom_range(255)));
                done++;
            end
            else if (r < 94)
            begin
                send_request(OP_TICK, sel, 8'($urandom_range(255)));
                done++;
            end
            else if (r < 96)
            begin
                send_request(OP_RESET, sel, 8'($urandom_range(255)));
                done++;
            end
            else
                // unused opcodes are dropped by the block
                send_request(3'($urandom_range(7, 5)), sel, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part: extremes, every opcode, envelope restart, unused ops
        write_reg(1'b0, REG_MIX, 8'h00);
        write_reg(1'b0, REG_VOL0, 8'h0F);
        write_reg(1'b0, 4'd9, 8'h10);
        write_reg(1'b0, 4'd0, 8'hFF);
        write_reg(1'b0, 4'd1, 8'hFF);
        write_reg(1'b0, REG_SHAPE, 8'h0D);
        read_reg(1'b0, REG_SHAPE);
        send_request(OP_TICK, 1'b0, 8'hFF);
        send_request(OP_TICK, 1'b1, 8'h00);
        write_reg(1'b1, 4'd15, 8'hAA);
        read_reg(1'b1, 4'd15);
        send_request(3'd5, 1'b0, 8'h00);
        send_request(3'd6, 1'b1, 8'hFF);
        send_request(3'd7, 1'b0, 8'h55);
        send_request(OP_RESET, 1'b0, 8'h00);
        read_reg(1'b0, 4'd0);
        send_request(OP_TICK, 1'b0, 8'h00);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            // step settings: defaults, then the extremes, then random
            case (phase)
                1:
                begin
                    set_step(CFG_TONE, 24'hFFFFFF);
                    set_step(CFG_ENV, 24'd1);
                    set_step(CFG_NOISE, 24'hFFFFFF);
                end
                2:
                begin
                    set_step(CFG_TONE, 24'd1);
                    set_step(CFG_ENV, 24'hFFFFFF);
                    set_step(CFG_NOISE, 24'd1);
                end
                3:
                begin
                    set_step(CFG_TONE, 24'($urandom_range(24'hFFFFFF, 1)));
                    set_step(CFG_ENV, 24'($urandom_range(24'h3FFFFF, 1)));
                    set_step(CFG_NOISE, 24'($urandom_range(24'hFFFFFF, 1)));
                end
                default: ;
            endcase
            // idle pattern per phase: none, sender, receiver, both
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            random_requests(RANDOM_PER_PHASE / 3);
            send_idle_pct = 0;
            stall_pct = 0;
            random_requests(RANDOM_PER_PHASE / 6);
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            random_requests(RANDOM_PER_PHASE / 2);
            send_idle_pct = 0;
            stall_pct = 0;
            drain();
        end

        // let any stray result show up
        repeat (2000) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: psg_sound_generator_pair.f
+incdir+hdl
hdl/psg_pkg.sv
hdl/psg_sub_unit.sv
hdl/psg_sound_generator_pair.sv
test/psg_pair_checker.sv
test/psg_sound_generator_pair_tb.sv
